>>> rtl/dll_pkg.sv
// Shared types and constants for the bounded doubly linked list.
package dll_pkg;

   localparam int unsigned DLL_CAPACITY = 32;

   localparam logic [2:0] CMD_INS_HEAD = 3'd0;
   localparam logic [2:0] CMD_INS_TAIL = 3'd1;
   localparam logic [2:0] CMD_INS_POS  = 3'd2;
   localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
   localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
   localparam logic [2:0] CMD_DEL_POS  = 3'd5;
   localparam logic [2:0] CMD_READ_OUT = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] elem_value;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {INS_FIRST, INS_HEAD, INS_TAIL, INS_MID} ins_kind_type;
   typedef enum logic [1:0] {VAL_ZERO, VAL_DELETED, VAL_TRAVERSE} val_sel_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_TRV_START, S_TRV_RUN, S_INS_ALLOC, S_INS_WRITE,
      S_INS_LINK, S_DEL_FIX, S_RESP_OK, S_RESP_ERR
   } state_type;

   typedef struct packed {
      logic         ins;
      logic         del;
      logic         rd;
      logic         nop;
      logic         ins_bad;
      logic         full;
      logic         empty;
      logic         del_bad;
      logic         hit;
      logic         rsp_free;
      ins_kind_type ins_kind;
   } dp_status_type;

   typedef struct packed {
      logic        req_load;
      logic        trv_first;
      logic        trv_adv;
      logic        trv_latch;
      logic        alloc;
      logic        ins_write;
      logic        ins_link;
      logic        del_fix;
      logic        rsp_load;
      logic [1:0]  rsp_status;
      val_sel_type rsp_val;
      logic        rsp_last;
   } dp_cmd_type;

endpackage

>>> rtl/dll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dll_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/dll_ctrl.sv
// Sequencing state machine for the linked list commands.
module dll_ctrl
   import dll_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (st.nop) begin
               state_in = S_IDLE;
            end else if (st.ins) begin
               if (st.ins_bad || st.full) state_in = S_RESP_ERR;
               else if (st.ins_kind == INS_MID) state_in = S_TRV_START;
               else state_in = S_INS_ALLOC;
            end else if (st.del) begin
               if (st.empty || st.del_bad) state_in = S_RESP_ERR;
               else state_in = S_TRV_START;
            end else begin
               if (st.empty) state_in = S_RESP_ERR;
               else state_in = S_TRV_START;
            end
         end
         S_TRV_START: state_in = S_TRV_RUN;
         S_TRV_RUN: begin
            if (st.rd) begin
               if (st.rsp_free && st.hit) state_in = S_IDLE;
            end else if (st.hit) begin
               state_in = st.del ? S_DEL_FIX : S_INS_ALLOC;
            end
         end
         S_INS_ALLOC: state_in = S_INS_WRITE;
         S_INS_WRITE: state_in = (st.ins_kind == INS_MID) ? S_INS_LINK : S_RESP_OK;
         S_INS_LINK:  state_in = S_RESP_OK;
         S_DEL_FIX:   state_in = S_RESP_OK;
         S_RESP_OK, S_RESP_ERR: begin
            if (st.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_val = VAL_ZERO;
      cmd.rsp_status = ST_OK;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.req_load = req_valid;
         end
         S_TRV_START: cmd.trv_first = 1'b1;
         S_TRV_RUN: begin
            if (st.rd) begin
               if (st.rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_val = VAL_TRAVERSE;
                  cmd.rsp_last = st.hit;
                  cmd.trv_adv = !st.hit;
               end
            end else if (st.hit) begin
               cmd.trv_latch = 1'b1;
            end else begin
               cmd.trv_adv = 1'b1;
            end
         end
         S_INS_ALLOC: cmd.alloc = 1'b1;
         S_INS_WRITE: cmd.ins_write = 1'b1;
         S_INS_LINK:  cmd.ins_link = 1'b1;
         S_DEL_FIX:   cmd.del_fix = 1'b1;
         S_RESP_OK: begin
            cmd.rsp_load = st.rsp_free;
            cmd.rsp_val = st.del ? VAL_DELETED : VAL_ZERO;
            cmd.rsp_last = 1'b1;
         end
         S_RESP_ERR: begin
            cmd.rsp_load = st.rsp_free;
            cmd.rsp_last = 1'b1;
            if (st.ins) cmd.rsp_status = st.ins_bad ? ST_BADPOS : ST_FULL;
            else if (st.del) cmd.rsp_status = st.empty ? ST_EMPTY : ST_BADPOS;
            else cmd.rsp_status = ST_EMPTY;
         end
         default: cmd.rsp_load = 1'b0;
      endcase
   end
endmodule

>>> rtl/dll_datapath.sv
// Link memories, list pointers, traversal engine and result register.
module dll_datapath
   import dll_pkg::*;
#(
   parameter int unsigned CAPACITY = DLL_CAPACITY
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  dp_cmd_type    cmd,
   output dp_status_type st
);
   localparam int unsigned SW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = ((CW > 8) ? CW : 8) + 1;

   req_type        req_ff;
   logic [CW-1:0]  count_ff, fsp_ff, fresh_ff, idx_ff;
   logic [SW-1:0]  head_ff, tail_ff, n_ff, addr_ff, s_ff, sn_ff, sprev_ff;
   logic [31:0]    sv_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic [SW-1:0]  trv_addr, trv_start;
   logic [31:0]    val_rdata;
   logic [SW-1:0]  next_rdata, prev_rdata, free_rdata;
   logic [CW-1:0]  fsp_dec;

   logic           next_we, prev_we;
   logic [SW-1:0]  next_wa, next_wd, prev_wa, prev_wd;

   logic [PW-1:0]  cnt_x, pos_x, p_ins, p_del, tgt;

   assign cnt_x = PW'(count_ff);
   assign pos_x = PW'(req_ff.position);

   always_comb begin
      case (req_ff.cmd)
         CMD_INS_HEAD: p_ins = PW'(1);
         CMD_INS_TAIL: p_ins = cnt_x + PW'(1);
         default:      p_ins = pos_x;
      endcase
      case (req_ff.cmd)
         CMD_DEL_HEAD: p_del = PW'(1);
         CMD_DEL_TAIL: p_del = cnt_x;
         default:      p_del = pos_x;
      endcase
   end

   // Target index of the walk, counted from the start node.
   always_comb begin
      if (st.rd) tgt = cnt_x - PW'(1);
      else if (req_ff.cmd == CMD_DEL_TAIL) tgt = '0;
      else if (st.del) tgt = p_del - PW'(1);
      else tgt = p_ins - PW'(2);
   end

   assign trv_start = (req_ff.cmd == CMD_DEL_TAIL) ? tail_ff : head_ff;

   always_comb begin
      st.ins      = (req_ff.cmd == CMD_INS_HEAD) || (req_ff.cmd == CMD_INS_TAIL)
                 || (req_ff.cmd == CMD_INS_POS);
      st.del      = (req_ff.cmd == CMD_DEL_HEAD) || (req_ff.cmd == CMD_DEL_TAIL)
                 || (req_ff.cmd == CMD_DEL_POS);
      st.rd       = (req_ff.cmd == CMD_READ_OUT);
      st.nop      = !(st.ins || st.del || st.rd);
      st.ins_bad  = (p_ins == '0) || (p_ins > cnt_x + PW'(1));
      st.full     = (count_ff == CW'(CAPACITY));
      st.empty    = (count_ff == '0);
      st.del_bad  = (p_del == '0) || (p_del > cnt_x);
      st.hit      = (idx_ff == tgt[CW-1:0]);
      st.rsp_free = !rsp_valid_ff || rsp_ready;
      if (count_ff == '0) st.ins_kind = INS_FIRST;
      else if (p_ins == PW'(1)) st.ins_kind = INS_HEAD;
      else if (p_ins > cnt_x) st.ins_kind = INS_TAIL;
      else st.ins_kind = INS_MID;
   end

   assign trv_addr = cmd.trv_first ? trv_start : (cmd.trv_adv ? next_rdata : addr_ff);
   assign fsp_dec  = fsp_ff - 1'b1;

   // Link writes: at most one per memory in any cycle.
   always_comb begin
      next_we = 1'b0; next_wa = n_ff; next_wd = n_ff;
      prev_we = 1'b0; prev_wa = n_ff; prev_wd = n_ff;
      if (cmd.ins_write) begin
         case (st.ins_kind)
            INS_HEAD: begin
               next_we = 1'b1; next_wa = n_ff;    next_wd = head_ff;
               prev_we = 1'b1; prev_wa = head_ff; prev_wd = n_ff;
            end
            INS_TAIL: begin
               prev_we = 1'b1; prev_wa = n_ff;    prev_wd = tail_ff;
               next_we = 1'b1; next_wa = tail_ff; next_wd = n_ff;
            end
            INS_MID: begin
               next_we = 1'b1; next_wa = n_ff; next_wd = sn_ff;
               prev_we = 1'b1; prev_wa = n_ff; prev_wd = s_ff;
            end
            default: next_we = 1'b0;
         endcase
      end else if (cmd.ins_link) begin
         next_we = 1'b1; next_wa = s_ff;  next_wd = n_ff;
         prev_we = 1'b1; prev_wa = sn_ff; prev_wd = n_ff;
      end else if (cmd.del_fix && count_ff != CW'(1) && p_del != PW'(1)
                   && p_del != cnt_x) begin
         next_we = 1'b1; next_wa = sprev_ff; next_wd = sn_ff;
         prev_we = 1'b1; prev_wa = sn_ff;    prev_wd = sprev_ff;
      end
   end

   dll_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_value (
      .clock(clock), .wr_en(cmd.ins_write), .wr_addr(n_ff), .wr_data(req_ff.value),
      .rd_addr(trv_addr), .rd_data(val_rdata));
   dll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(trv_addr), .rd_data(next_rdata));
   dll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(trv_addr), .rd_data(prev_rdata));
   // Released slots are stacked here; never-used slots come from the fresh counter.
   dll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
      .clock(clock), .wr_en(cmd.del_fix), .wr_addr(fsp_ff[SW-1:0]), .wr_data(s_ff),
      .rd_addr(fsp_dec[SW-1:0]), .rd_data(free_rdata));

   always_ff @(posedge clock) begin
      if (cmd.req_load) req_ff <= req_data;
      addr_ff <= trv_addr;
      if (cmd.trv_latch) begin
         s_ff     <= addr_ff;
         sn_ff    <= next_rdata;
         sprev_ff <= prev_rdata;
         sv_ff    <= val_rdata;
      end
      if (cmd.alloc) n_ff <= (fsp_ff != '0) ? free_rdata : fresh_ff[SW-1:0];
      if (cmd.rsp_load) begin
         rsp_ff.status <= cmd.rsp_status;
         rsp_ff.last   <= cmd.rsp_last;
         case (cmd.rsp_val)
            VAL_DELETED:  rsp_ff.elem_value <= sv_ff;
            VAL_TRAVERSE: rsp_ff.elem_value <= val_rdata;
            default:      rsp_ff.elem_value <= '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fsp_ff       <= '0;
         fresh_ff     <= '0;
         idx_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.trv_first) idx_ff <= '0;
         else if (cmd.trv_adv) idx_ff <= idx_ff + 1'b1;

         if (cmd.alloc) begin
            if (fsp_ff != '0) fsp_ff <= fsp_dec;
            else fresh_ff <= fresh_ff + 1'b1;
         end

         if (cmd.ins_write) begin
            count_ff <= count_ff + 1'b1;
            case (st.ins_kind)
               INS_FIRST: begin head_ff <= n_ff; tail_ff <= n_ff; end
               INS_HEAD:  head_ff <= n_ff;
               INS_TAIL:  tail_ff <= n_ff;
               default:   head_ff <= head_ff;
            endcase
         end

         if (cmd.del_fix) begin
            count_ff <= count_ff - 1'b1;
            fsp_ff   <= fsp_ff + 1'b1;
            if (count_ff == CW'(1)) begin
               head_ff <= '0;
               tail_ff <= '0;
            end else if (p_del == PW'(1)) begin
               head_ff <= sn_ff;
            end else if (p_del == cnt_x) begin
               tail_ff <= sprev_ff;
            end
         end

         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

>>> rtl/bounded_doubly_linked_list.sv
// Bounded doubly linked list of 32-bit signed values with a fixed slot pool.
// One command is handled at a time. Head and tail inserts need no walk. Every
// delete and every insert at an inner position walks the forward links one
// memory read per cycle; a delete at the head counts as position 1, and a
// delete at the tail starts its walk at the tail. A read out walks the list
// in the same way and waits whenever the result side stalls. Each result
// leaves through a register, and a rejected command answers without a walk.
// No clearing pass is needed after reset.
module bounded_doubly_linked_list
   import dll_pkg::*;
#(
   parameter int unsigned CAPACITY = DLL_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   dp_status_type st;
   dp_cmd_type    cmd;

   dll_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .st(st), .cmd(cmd));

   dll_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock(clock), .reset(reset), .req_data(req_data), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_data(rsp_data), .cmd(cmd), .st(st));
endmodule

>>> rtl/dll_checker.sv
// Port-level checks for the linked list block, bound to the top level.
module dll_checker
   import dll_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   // A stalled result transfer keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Commands are handled one at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new command taken while one is in progress");

   // Failed commands carry a zero value and close their command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.elem_value == '0 && rsp_data.last)
      else $error("bad error result");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present after reset");
endmodule

bind bounded_doubly_linked_list dll_checker u_dll_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));

>>> dv/bounded_doubly_linked_list_tb.sv
// Testbench for the bounded doubly linked list: directed table, a capacity fill, then random commands.
`timescale 1ns / 100ps

module bounded_doubly_linked_list_tb;
   import dll_pkg::*;

   localparam int CAP = DLL_CAPACITY;
   localparam int N_RANDOM = 260;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   bounded_doubly_linked_list dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // The list contents in order from head to tail.
   logic signed [31:0] list_q[$];
   rsp_type expected_rsp_q[$];
   int mismatches = 0;
   bit quiet = 0;
   bit hold_rsp = 0;

   always #6 clock = ~clock;

   // Works out the responses of one accepted command and updates the list.
   task automatic apply_command(input req_type r);
      rsp_type o;
      int cnt;
      int p;
      cnt = list_q.size();
      o = '0;
      o.last = 1'b1;
      case (r.cmd)
         CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
            p = (r.cmd == CMD_INS_HEAD) ? 1 : (r.cmd == CMD_INS_TAIL) ? cnt + 1 : r.position;
            if (p == 0 || p > cnt + 1) o.status = ST_BADPOS;
            else if (cnt >= CAP) o.status = ST_FULL;
            else begin
               o.status = ST_OK;
               list_q.insert(p - 1, r.value);
            end
            expected_rsp_q.push_back(o);
         end
         CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
            p = (r.cmd == CMD_DEL_HEAD) ? 1 : (r.cmd == CMD_DEL_TAIL) ? cnt : r.position;
            if (cnt == 0) o.status = ST_EMPTY;
            else if (p == 0 || p > cnt) o.status = ST_BADPOS;
            else begin
               o.status = ST_OK;
               o.elem_value = list_q[p - 1];
               list_q.delete(p - 1);
            end
            expected_rsp_q.push_back(o);
         end
         CMD_READ_OUT: begin
            if (cnt == 0) begin
               o.status = ST_EMPTY;
               expected_rsp_q.push_back(o);
            end else begin
               for (int i = 0; i < cnt; i++) begin
                  o.status = ST_OK;
                  o.elem_value = list_q[i];
                  o.last = (i == cnt - 1);
                  expected_rsp_q.push_back(o);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Compares a value typed into the directed table with the predictor's answer.
   task automatic check_typed(input rsp_type want);
      rsp_type got;
      got = expected_rsp_q[$];
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees: typed %p predicted %p", want, got);
      end
   endtask

   // Valid stays high from one transfer to the next unless an idle burst is drawn.
   task automatic send(input req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_command(r);
   endtask

   function automatic req_type make_cmd(input logic [2:0] c, input logic signed [31:0] v,
                                        input logic [7:0] p);
      req_type r;
      r.cmd = c;
      r.value = v;
      r.position = p;
      return r;
   endfunction

   // Receiver: random stalls in bursts, or a long hold-off on request.
   initial begin
      int burst;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_rsp = 0;
         end
         if (!quiet && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 6);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer %p", rsp_data);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status || rsp_data.elem_value !== want.elem_value
                || rsp_data.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   initial begin
      #30_000_000;
      $display("FAILURE");
      $finish;
   end

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } table_row_type;

   initial begin
      table_row_type rows[$];
      req_type r;
      int pick;
      int sz;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty-list errors, bad positions, extremes, every command.
      rows = '{
         '{make_cmd(CMD_READ_OUT, 0, 0), 1, '{ST_EMPTY, 0, 1'b1}},
         '{make_cmd(CMD_DEL_HEAD, 0, 0), 1, '{ST_EMPTY, 0, 1'b1}},
         '{make_cmd(CMD_DEL_TAIL, 0, 0), 1, '{ST_EMPTY, 0, 1'b1}},
         '{make_cmd(CMD_DEL_POS, 0, 0), 1, '{ST_EMPTY, 0, 1'b1}},
         '{make_cmd(CMD_INS_POS, 5, 0), 1, '{ST_BADPOS, 0, 1'b1}},
         '{make_cmd(CMD_INS_POS, 5, 2), 1, '{ST_BADPOS, 0, 1'b1}},
         '{make_cmd(CMD_INS_POS, 32'sh7FFFFFFF, 1), 1, '{ST_OK, 0, 1'b1}},
         '{make_cmd(CMD_INS_HEAD, 32'sh80000000, 0), 1, '{ST_OK, 0, 1'b1}},
         '{make_cmd(CMD_INS_TAIL, -1, 8'hFF), 1, '{ST_OK, 0, 1'b1}},
         '{make_cmd(CMD_INS_POS, 32'h55AA55AA, 4), 0, '{ST_OK, 0, 1'b1}},
         '{make_cmd(CMD_INS_POS, 32'h2AD52AD5, 2), 0, '{ST_OK, 0, 1'b1}},
         '{make_cmd(CMD_INS_POS, 1, 8'hFF), 1, '{ST_BADPOS, 0, 1'b1}},
         '{make_cmd(3'd7, 9, 1), 0, '{ST_OK, 0, 1'b1}},
         '{make_cmd(CMD_READ_OUT, 0, 0), 0, '{ST_OK, 0, 1'b1}},
         '{make_cmd(CMD_DEL_POS, 0, 0), 1, '{ST_BADPOS, 0, 1'b1}},
         '{make_cmd(CMD_DEL_POS, 0, 6), 1, '{ST_BADPOS, 0, 1'b1}},
         '{make_cmd(CMD_DEL_POS, 0, 3), 0, '{ST_OK, 0, 1'b1}},
         '{make_cmd(CMD_DEL_HEAD, 0, 0), 1, '{ST_OK, 32'sh80000000, 1'b1}},
         '{make_cmd(CMD_DEL_TAIL, 0, 0), 1, '{ST_OK, 32'h55AA55AA, 1'b1}},
         '{make_cmd(CMD_DEL_POS, 0, 2), 1, '{ST_OK, -1, 1'b1}},
         '{make_cmd(CMD_DEL_POS, 0, 1), 1, '{ST_OK, 32'h2AD52AD5, 1'b1}},
         '{make_cmd(CMD_READ_OUT, 0, 0), 1, '{ST_EMPTY, 0, 1'b1}}
      };
      foreach (rows[i]) begin
         send(rows[i].req);
         if (rows[i].typed) check_typed(rows[i].want);
      end

      // Fill to capacity, push past it, and read out while the receiver holds off.
      for (int i = 0; i < CAP; i++) send(make_cmd(CMD_INS_TAIL, $urandom, 0));
      send(make_cmd(CMD_INS_HEAD, 3, 0));
      check_typed('{ST_FULL, 0, 1'b1});
      send(make_cmd(CMD_INS_POS, 3, 8'(CAP + 1)));
      check_typed('{ST_FULL, 0, 1'b1});
      hold_rsp = 1;
      send(make_cmd(CMD_READ_OUT, 0, 0));
      for (int i = 0; i < 6; i++) send(make_cmd(CMD_DEL_POS, 0, 8'($urandom_range(1, 20))));

      // Random part: biased so the length wanders over the whole range.
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 40) quiet = 1;
         sz = list_q.size();
         pick = $urandom_range(0, 99);
         r.value = $urandom;
         if (pick < 6) r.position = 8'($urandom);
         else r.position = 8'($urandom_range(0, sz + 1));
         if (pick < 2) r.cmd = 3'd7;
         else if (pick < 8) r.cmd = CMD_READ_OUT;
         else if ((n / 60) % 2 == 0)
            r.cmd = (pick < 70) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(3, 5));
         else r.cmd = (pick < 30) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(3, 5));
         send(r);
      end
      req_valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_rsp_q.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
